// ===== design/pao_pkg.sv =====
// ----------------------------------------------------------------------------
// pao_pkg
// Shared widths, constants, waveform codes and the quarter-wave sine
// generator used to build the oscillator's sine ROM at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

package pao_pkg;

    localparam int FREQ_W     = 19;
    localparam int PW_W       = 16;
    localparam int SAMPLE_W   = 16;
    localparam int PHASE_W    = 32;
    localparam int ROM_DATA_W = 15;

    localparam int DEF_SAMPLE_RATE      = 48000;
    localparam int DEF_SINE_TABLE_DEPTH = 1024;

    // reciprocal of the sample rate: inc = (freq * M) >> RECIP_SHIFT,
    // M = floor(2^(28 + RECIP_SHIFT) / rate) + 1, exact for 19-bit freq
    // at any rate below 2^18
    localparam int RECIP_SHIFT = 37;
    localparam int RECIP_W     = 54;
    localparam int RECIP_SPLIT = 27;
    localparam int PROD_W      = FREQ_W + RECIP_SPLIT;
    localparam int SUM_W       = FREQ_W + RECIP_W;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
    localparam logic [63:0] ROUND_Q30   = 64'd1 << 29;
    localparam logic [63:0] FULL_SCALE  = 64'd32767;

    // (2n)(2n+1) for the taylor terms n = 1 .. 6
    localparam logic [63:0] TAYLOR_DIV [1:6] = '{64'd6, 64'd20, 64'd42,
                                                 64'd72, 64'd110, 64'd156};

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_POS = 16'sd32767;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_NEG = -16'sd32767;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sd32768;

    typedef enum logic [1:0] {
        WAVE_SINE   = 2'd0,
        WAVE_SAW    = 2'd1,
        WAVE_SQUARE = 2'd2,
        WAVE_SILENT = 2'd3
    } t_waveform;

    // quarter-wave entry j of a table of 2^log2d steps, Q30 taylor series
    function automatic logic [ROM_DATA_W-1:0] quarter_sine(input logic [63:0] j,
                                                            input int log2d);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r;
        x    = (HALF_PI_Q30 * j) >> log2d;
        term = x;
        sum  = x;
        for (int n = 1; n <= 6; n++) begin
            term = (term * x) >> 30;
            term = ((term * x) >> 30) / TAYLOR_DIV[n];
            if (n % 2 == 1) begin
                sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
                sum = sum + term;
            end
        end
        if (sum > ONE_Q30) begin
            sum = ONE_Q30;
        end
        r = (sum * FULL_SCALE + ROUND_Q30) >> 30;
        if (r > FULL_SCALE) begin
            r = FULL_SCALE;
        end
        return r[ROM_DATA_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/phase_accumulator_oscillator.sv =====
// Pipeline: a request accepted into the input register passes two more multiply
//   stages, the phase add, the sine ROM read and the output register before its
//   sample shows on o_out_valid.
// Throughput: one request per cycle unless the output stalls; the 32-bit phase
// add is the only loop. Output back pressure stalls the whole pipeline together.
// Reset: synchronous, active low; clears the phase, waveform (sine) and valids.
// ----------------------------------------------------------------------------
// phase_accumulator_oscillator
// Phase-accumulator oscillator producing sine, sawtooth or square samples in
// Q1.15 from a frequency and pulse-width request stream.
// SINE_TABLE_DEPTH must be a power of two.
// ----------------------------------------------------------------------------
`default_nettype none

module phase_accumulator_oscillator import pao_pkg::*; #(
    parameter int SAMPLE_RATE      = DEF_SAMPLE_RATE,
    parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [FREQ_W-1:0]           i_frequency,
    input  logic [PW_W-1:0]             i_pulse_width,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [SAMPLE_W-1:0]  o_sample
);

    localparam int LOG2_DEPTH = $clog2(SINE_TABLE_DEPTH);
    localparam int ADDR_W     = LOG2_DEPTH + 1;

    logic                        w_adv;
    logic                        w_inc_valid;
    logic [PHASE_W-1:0]          w_inc;
    logic [PW_W-1:0]             w_inc_pw;
    logic [ROM_DATA_W-1:0]       w_rom_data;

    t_waveform                   r_waveform;
    logic [PHASE_W-1:0]          r_phase;
    logic [PHASE_W-1:0]          n_phase;
    logic [ADDR_W-1:0]           n_addr;

    logic                        r_s4_valid;
    logic [ADDR_W-1:0]           r_s4_addr;
    logic                        r_s4_neg;
    logic [SAMPLE_W-1:0]         r_s4_saw;
    logic                        r_s4_sq_hi;

    logic                        r_s5_valid;
    logic                        r_s5_neg;
    logic [SAMPLE_W-1:0]         r_s5_saw;
    logic                        r_s5_sq_hi;

    logic                        r_out_valid;
    logic signed [SAMPLE_W-1:0]  r_sample;
    logic signed [SAMPLE_W-1:0]  n_sample;
    logic signed [SAMPLE_W-1:0]  n_sine;

    assign w_adv      = !r_out_valid || i_out_ready;
    assign o_in_ready = w_adv;

    pao_increment #(
        .SAMPLE_RATE(SAMPLE_RATE)
    ) u_increment (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_adv),
        .i_valid       (i_in_valid),
        .i_frequency   (i_frequency),
        .i_pulse_width (i_pulse_width),
        .o_valid       (w_inc_valid),
        .o_inc         (w_inc),
        .o_pulse_width (w_inc_pw)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waveform <= WAVE_SINE;
        end else if (i_cfg_we) begin
            r_waveform <= t_waveform'(i_cfg_wdata);
        end
    end

    // phase update and sine address folding
    always_comb begin
        n_phase = r_phase + w_inc;
        if (n_phase[PHASE_W-2]) begin
            n_addr = ADDR_W'(SINE_TABLE_DEPTH)
                   - {1'b0, n_phase[PHASE_W-3 -: LOG2_DEPTH]};
        end else begin
            n_addr = {1'b0, n_phase[PHASE_W-3 -: LOG2_DEPTH]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_s4_valid  <= 1'b0;
            r_s5_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            if (w_inc_valid) begin
                r_phase <= n_phase;
            end
            r_s4_valid  <= w_inc_valid;
            r_s5_valid  <= r_s4_valid;
            r_out_valid <= r_s5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s4_addr  <= n_addr;
            r_s4_neg   <= n_phase[PHASE_W-1];
            // phase[31:16] - 32768 is the top half with its msb flipped
            r_s4_saw   <= {~n_phase[PHASE_W-1], n_phase[PHASE_W-2 -: SAMPLE_W-1]};
            r_s4_sq_hi <= n_phase > {w_inc_pw, {(PHASE_W-PW_W){1'b0}}};
            r_s5_neg   <= r_s4_neg;
            r_s5_saw   <= r_s4_saw;
            r_s5_sq_hi <= r_s4_sq_hi;
            r_sample   <= n_sample;
        end
    end

    pao_sine_rom #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
    ) u_sine_rom (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_addr (r_s4_addr),
        .o_data (w_rom_data)
    );

    always_comb begin
        n_sine = $signed({1'b0, w_rom_data});
        if (r_s5_neg) begin
            n_sine = -n_sine;
        end
        unique case (r_waveform)
            WAVE_SINE:   n_sample = n_sine;
            WAVE_SAW:    n_sample = $signed(r_s5_saw);
            WAVE_SQUARE: n_sample = r_s5_sq_hi ? SAMPLE_POS : SAMPLE_NEG;
            WAVE_SILENT: n_sample = '0;
            default:     n_sample = '0;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;

    // phase moves only when an increment leaves the multiplier
    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_adv && w_inc_valid) |=> $stable(r_phase))
        else $error("phase changed without an increment");

    a_square_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_waveform == WAVE_SQUARE)
            |-> (o_sample == SAMPLE_POS || o_sample == SAMPLE_NEG))
        else $error("square sample not at full scale");

    a_sine_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_waveform == WAVE_SINE) |-> (o_sample != SAMPLE_MIN))
        else $error("sine sample out of range");

    a_silent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_waveform == WAVE_SILENT) |-> (o_sample == '0))
        else $error("silent waveform gave a nonzero sample");

endmodule

`default_nettype wire

// ===== design/pao_increment.sv =====
// ----------------------------------------------------------------------------
// pao_increment
// Turns a frequency in 1/16 Hz into a 32-bit phase increment through a
// two-part reciprocal multiply over three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module pao_increment import pao_pkg::*; #(
    parameter int SAMPLE_RATE = DEF_SAMPLE_RATE
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [FREQ_W-1:0]   i_frequency,
    input  logic [PW_W-1:0]     i_pulse_width,
    output logic                o_valid,
    output logic [PHASE_W-1:0]  o_inc,
    output logic [PW_W-1:0]     o_pulse_width
);

    localparam logic [95:0] RECIP_FULL =
        ((96'd1 << (28 + RECIP_SHIFT)) / 96'(SAMPLE_RATE)) + 96'd1;
    localparam logic [RECIP_SPLIT-1:0] RECIP_HI = RECIP_FULL[RECIP_W-1:RECIP_SPLIT];
    localparam logic [RECIP_SPLIT-1:0] RECIP_LO = RECIP_FULL[RECIP_SPLIT-1:0];

    logic                r_s1_valid;
    logic [FREQ_W-1:0]   r_s1_freq;
    logic [PW_W-1:0]     r_s1_pw;
    logic                r_s2_valid;
    logic [PROD_W-1:0]   r_s2_prod_hi;
    logic [PROD_W-1:0]   r_s2_prod_lo;
    logic [PW_W-1:0]     r_s2_pw;
    logic                r_s3_valid;
    logic [PHASE_W-1:0]  r_s3_inc;
    logic [PW_W-1:0]     r_s3_pw;
    logic [SUM_W-1:0]    n_sum;

    always_comb begin
        n_sum = {r_s2_prod_hi, {RECIP_SPLIT{1'b0}}} + SUM_W'(r_s2_prod_lo);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_freq    <= i_frequency;
            r_s1_pw      <= i_pulse_width;
            r_s2_prod_hi <= PROD_W'(r_s1_freq) * PROD_W'(RECIP_HI);
            r_s2_prod_lo <= PROD_W'(r_s1_freq) * PROD_W'(RECIP_LO);
            r_s2_pw      <= r_s1_pw;
            // wraps modulo a full phase turn by dropping the upper product bits
            r_s3_inc     <= n_sum[RECIP_SHIFT +: PHASE_W];
            r_s3_pw      <= r_s2_pw;
        end
    end

    assign o_valid       = r_s3_valid;
    assign o_inc         = r_s3_inc;
    assign o_pulse_width = r_s3_pw;

endmodule

`default_nettype wire

// ===== design/pao_sine_rom.sv =====
// ----------------------------------------------------------------------------
// pao_sine_rom
// Quarter-wave sine ROM with SINE_TABLE_DEPTH + 1 entries and a registered
// read port; contents are computed at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

module pao_sine_rom import pao_pkg::*; #(
    parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [$clog2(SINE_TABLE_DEPTH):0] i_addr,
    output logic [ROM_DATA_W-1:0]         o_data
);

    localparam int LOG2_DEPTH = $clog2(SINE_TABLE_DEPTH);

    typedef logic [ROM_DATA_W-1:0] t_rom_data;
    typedef t_rom_data t_rom [0:SINE_TABLE_DEPTH];

    function automatic t_rom build_rom();
        t_rom rom;
        for (int j = 0; j <= SINE_TABLE_DEPTH; j++) begin
            rom[j] = quarter_sine(64'(j), LOG2_DEPTH);
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    logic [ROM_DATA_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= SINE_ROM[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

// ===== test/tb_phase_accumulator_oscillator.sv =====
// ----------------------------------------------------------------------------
// tb_phase_accumulator_oscillator
// Self-checking bench for the phase-accumulator oscillator. A scoreboard
// class tracks the phase and the waveform register, predicts the sample for
// every accepted request and checks the samples in order. Directed corner
// requests run under each waveform code, then random requests run across
// several waveform settings with random stalls on both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_phase_accumulator_oscillator import pao_pkg::*;;

    localparam int RATE           = DEF_SAMPLE_RATE;
    localparam int DEPTH          = DEF_SINE_TABLE_DEPTH;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 80;
    localparam int PHASE_REQUESTS = 100;
    localparam int FREQ_TOP       = 384000;

    class osc_scoreboard;
        logic [PHASE_W-1:0]         phase;
        t_waveform                  waveform;
        logic signed [SAMPLE_W-1:0] expected_samples[$];
        int unsigned                quarter_rom[DEPTH+1];
        int                         errors;
        int                         requests;
        int                         checked;
        int                         per_wave[4];

        // taylor series of sin((pi/2) j / DEPTH) in Q30, scaled to Q15
        function int unsigned quarter_wave(int j);
            longint unsigned x;
            longint unsigned term;
            longint unsigned acc;
            longint unsigned r;
            x    = (64'd1686629713 * longint'(j)) / DEPTH;
            term = x;
            acc  = x;
            for (int n = 1; n <= 6; n++) begin
                term = (term * x) >> 30;
                term = ((term * x) >> 30) / ((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    acc = (acc >= term) ? acc - term : 0;
                end else begin
                    acc = acc + term;
                end
            end
            if (acc > (64'd1 << 30)) begin
                acc = 64'd1 << 30;
            end
            r = (acc * 32767 + (64'd1 << 29)) >> 30;
            if (r > 32767) begin
                r = 32767;
            end
            return int'(r);
        endfunction

        function new();
            phase    = '0;
            waveform = WAVE_SINE;
            errors   = 0;
            requests = 0;
            checked  = 0;
            per_wave = '{0, 0, 0, 0};
            for (int j = 0; j <= DEPTH; j++) begin
                quarter_rom[j] = quarter_wave(j);
            end
        endfunction

        function void set_waveform(t_waveform w);
            waveform = w;
        endfunction

        function void note_request(logic [FREQ_W-1:0] freq, logic [PW_W-1:0] pw);
            longint unsigned            inc;
            longint unsigned            idx;
            int unsigned                quad;
            int unsigned                pos;
            int                         mag;
            logic signed [SAMPLE_W-1:0] s;
            inc   = (longint'(freq) << 28) / RATE;
            phase = phase + inc[PHASE_W-1:0];
            case (waveform)
                WAVE_SINE: begin
                    idx  = (longint'(phase) * 4 * DEPTH) >> 32;
                    quad = int'(idx / DEPTH);
                    pos  = int'(idx % DEPTH);
                    mag  = (quad % 2 == 1) ? quarter_rom[DEPTH - pos] : quarter_rom[pos];
                    s    = (quad >= 2) ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
                end
                WAVE_SAW: begin
                    s = SAMPLE_W'(int'(phase >> 16) - 32768);
                end
                WAVE_SQUARE: begin
                    s = (phase > {pw, 16'h0000}) ? SAMPLE_POS : SAMPLE_NEG;
                end
                default: begin
                    s = '0;
                end
            endcase
            expected_samples.push_back(s);
            requests++;
            per_wave[waveform]++;
        endfunction

        function void check_sample(logic signed [SAMPLE_W-1:0] got);
            logic signed [SAMPLE_W-1:0] want;
            if (expected_samples.size() == 0) begin
                $display("%0t: sample %0d with no request outstanding", $time, got);
                errors++;
            end else begin
                want = expected_samples.pop_front();
                checked++;
                if (got !== want) begin
                    $display("%0t: sample mismatch, expected %0d, actual %0d",
                             $time, want, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [1:0]                 i_cfg_wdata;
    logic                       i_in_valid;
    logic                       o_in_ready;
    logic [FREQ_W-1:0]          i_frequency;
    logic [PW_W-1:0]            i_pulse_width;
    logic                       o_out_valid;
    logic                       i_out_ready;
    logic signed [SAMPLE_W-1:0] o_sample;

    osc_scoreboard sb;
    bit            no_idle;
    bit            burst_mode;
    bit            hold_req;
    bit            hold_done;
    int            stall_left;
    int            quiet_cycles;

    phase_accumulator_oscillator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_frequency   (i_frequency),
        .i_pulse_width (i_pulse_width),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_sample      (o_sample)
    );

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // inputs change on the falling edge; called and returns at a falling edge
    task automatic send_request(logic [FREQ_W-1:0] freq, logic [PW_W-1:0] pw);
        i_in_valid    <= 1'b1;
        i_frequency   <= freq;
        i_pulse_width <= pw;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        sb.note_request(freq, pw);
        @(negedge i_clk);
    endtask

    task automatic maybe_idle();
        if (!no_idle && !burst_mode && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        // let the pipeline settle
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_waveform(t_waveform w);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= w;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_waveform(w);
    endtask

    task automatic random_request();
        logic [FREQ_W-1:0] freq;
        logic [PW_W-1:0]   pw;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: freq = FREQ_W'($urandom_range(0, FREQ_TOP));
            6, 7:             freq = FREQ_W'($urandom_range(0, 2000));
            8:                freq = FREQ_W'($urandom);
            default:          freq = ($urandom_range(0, 1) == 0) ? '0 : '1;
        endcase
        case ($urandom_range(0, 7))
            0:       pw = '0;
            1:       pw = '1;
            default: pw = PW_W'($urandom);
        endcase
        maybe_idle();
        send_request(freq, pw);
    endtask

    // output side: random stall bursts plus one long hold-off
    initial begin
        i_out_ready = 1'b0;
        stall_left  = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (hold_req && !hold_done) begin
                hold_done   = 1'b1;
                stall_left  = HOLD_CYCLES - 1;
                i_out_ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 7) == 0) begin
                stall_left  = $urandom_range(1, 14) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_sample(o_sample);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_waveform corner_waves[4];
        t_waveform random_waves[9];
        sb            = new();
        quiet_cycles  = 0;
        no_idle       = 1'b0;
        burst_mode    = 1'b0;
        hold_req      = 1'b0;
        hold_done     = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = WAVE_SINE;
        i_in_valid    = 1'b0;
        i_frequency   = '0;
        i_pulse_width = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // corner requests under every waveform code, silence included
        corner_waves = '{WAVE_SINE, WAVE_SAW, WAVE_SQUARE, WAVE_SILENT};
        foreach (corner_waves[w]) begin
            write_waveform(corner_waves[w]);
            send_request('0, '0);
            send_request('1, '1);
            send_request(FREQ_W'(FREQ_TOP), '0);
            send_request(FREQ_W'(1), 16'h8000);
            send_request(FREQ_W'(FREQ_TOP / 2), 16'h7fff);
        end

        random_waves = '{WAVE_SAW, WAVE_SQUARE, WAVE_SINE, WAVE_SILENT, WAVE_SQUARE,
                         WAVE_SINE, WAVE_SAW, WAVE_SQUARE, WAVE_SINE};
        foreach (random_waves[p]) begin
            write_waveform(random_waves[p]);
            burst_mode = (p == 4);
            no_idle    = (p >= 7);
            for (int i = 0; i < PHASE_REQUESTS; i++) begin
                // output held off while the input keeps offering requests
                if (burst_mode && i == 4) begin
                    hold_req = 1'b1;
                end
                random_request();
            end
            burst_mode = 1'b0;
        end
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);

        $display("%0d requests, %0d samples checked: sine %0d, saw %0d, square %0d, silent %0d",
                 sb.requests, sb.checked, sb.per_wave[WAVE_SINE], sb.per_wave[WAVE_SAW],
                 sb.per_wave[WAVE_SQUARE], sb.per_wave[WAVE_SILENT]);
        $display("random stalls on both sides, one %0d-cycle output hold-off, %0d errors",
                 HOLD_CYCLES, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
